/* sv/wmss_pkg.sv */
package wmss_pkg;

    // sample and result geometry
    localparam int CHANNELS       = 6;
    localparam int CH_W           = 3;
    localparam logic [CH_W-1:0] LAST_CH = 3'd5;
    localparam int SMP_W          = 16;
    localparam int SPREAD_W       = 31;
    localparam int USED_W         = 8;
    // standard deviation carries 8 fraction bits: root of d * 2^16
    localparam int SCALE_W        = 16;

    localparam int DEF_MAX_WINDOW = 128;

    // register file
    localparam int APB_DATA_W     = 32;
    localparam int ADDR_W         = 3;
    localparam int REG_IDX_W      = 1;
    localparam logic [REG_IDX_W-1:0] REG_RESULT_MODE = 1'b0;

    localparam logic MODE_STDDEV   = 1'b0;
    localparam logic MODE_VARIANCE = 1'b1;

    typedef logic signed [SMP_W-1:0] t_sample;

endpackage

/* sv/window_mean_stddev_six_axis.sv */
// Per sample: square and accumulate each of six channels on one multiplier (S_SQ, then S_SA).
// Window end adds, per channel, set-up states S_M1, S_M2 and S_D (plus S_NN in variance mode),
// a bit-pair square root (standard deviation only) and a restoring divide on one shared
// subtract/compare unit; the strobe is registered together with the last channel's result.
// A sample arriving with the window full does not make the block busy unless it ends the window.
// Synchronous active-low reset clears the accumulators, the mode register and the strobe.
module window_mean_stddev_six_axis #(
    parameter int MAX_WINDOW = wmss_pkg::DEF_MAX_WINDOW
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wmss_pkg::ADDR_W-1:0]          paddr,
    input  logic [wmss_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wmss_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [wmss_pkg::SMP_W-1:0]    i_accel_x,
    input  logic signed [wmss_pkg::SMP_W-1:0]    i_accel_y,
    input  logic signed [wmss_pkg::SMP_W-1:0]    i_accel_z,
    input  logic signed [wmss_pkg::SMP_W-1:0]    i_gyro_x,
    input  logic signed [wmss_pkg::SMP_W-1:0]    i_gyro_y,
    input  logic signed [wmss_pkg::SMP_W-1:0]    i_gyro_z,
    input  logic                                 i_window_end,
    output logic                                 o_valid,
    output logic [wmss_pkg::SPREAD_W-1:0]        o_accel_x_spread,
    output logic [wmss_pkg::SPREAD_W-1:0]        o_accel_y_spread,
    output logic [wmss_pkg::SPREAD_W-1:0]        o_accel_z_spread,
    output logic [wmss_pkg::SPREAD_W-1:0]        o_gyro_x_spread,
    output logic [wmss_pkg::SPREAD_W-1:0]        o_gyro_y_spread,
    output logic [wmss_pkg::SPREAD_W-1:0]        o_gyro_z_spread,
    output logic [wmss_pkg::USED_W-1:0]          o_samples_used,
    output logic                                 o_window_overflow
);

    localparam int CHN    = wmss_pkg::CHANNELS;
    localparam int SMP_W  = wmss_pkg::SMP_W;
    localparam int CH_W   = wmss_pkg::CH_W;
    localparam int SPR_W  = wmss_pkg::SPREAD_W;
    localparam int USED_W = wmss_pkg::USED_W;
    localparam int SCL_W  = wmss_pkg::SCALE_W;

    localparam int LOG_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SMP_W + LOG_W;
    localparam int SQ_W   = 2 * SMP_W - 1 + LOG_W;
    localparam int MA_W   = SQ_W;
    localparam int MB_W   = SUM_W;
    localparam int P_W    = MA_W + MB_W;
    localparam int D_W    = (2 * SUM_W > CNT_W + SQ_W) ? 2 * SUM_W : CNT_W + SQ_W;
    localparam int X_W    = D_W + SCL_W + (D_W % 2);
    localparam int RT_W   = X_W / 2;
    localparam int DVS_W  = 2 * CNT_W;
    localparam int R_W    = (RT_W + 2 > DVS_W + 1) ? RT_W + 2 : DVS_W + 1;
    localparam int STEP_W = $clog2(X_W);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_SA   = 4'd2;
    localparam logic [3:0] S_M1   = 4'd3;
    localparam logic [3:0] S_M2   = 4'd4;
    localparam logic [3:0] S_D    = 4'd5;
    localparam logic [3:0] S_NN   = 4'd6;
    localparam logic [3:0] S_RT   = 4'd7;
    localparam logic [3:0] S_DV   = 4'd8;

    logic [3:0]              r_state;
    logic [CH_W-1:0]         r_ch;
    logic [STEP_W-1:0]       r_step;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_ovf_seen;
    logic                    r_mode;
    logic                    r_done;
    logic                    r_end;
    logic [USED_W-1:0]       r_used;
    logic                    r_ovf_out;

    wmss_pkg::t_sample       r_smp    [CHN];
    logic signed [SUM_W-1:0] r_sum    [CHN];
    logic [SQ_W-1:0]         r_sq     [CHN];
    logic [SPR_W-1:0]        r_spread [CHN];

    logic [P_W-1:0]          r_prod;
    logic [D_W-1:0]          r_a;
    logic [X_W-1:0]          r_x;
    logic [R_W-1:0]          r_rem;
    logic [RT_W-1:0]         r_root;
    logic [DVS_W-1:0]        r_dvs;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_cfg_wr;
    logic [SMP_W-1:0]        w_smag;
    logic [SUM_W-1:0]        w_mag;
    logic [MA_W-1:0]         w_mul_a;
    logic [MB_W-1:0]         w_mul_b;
    logic [P_W-1:0]          w_mul;
    logic                    w_dpos;
    logic [D_W-1:0]          w_d;
    logic [R_W-1:0]          w_cand;
    logic [R_W-1:0]          w_trial;
    logic [R_W-1:0]          w_diff;
    logic                    w_ge;
    logic [R_W-1:0]          n_rem;
    logic [RT_W-1:0]         n_root;
    logic [X_W-1:0]          n_quo;
    logic [CNT_W+USED_W-1:0] w_cnt_ext;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_cnt == CNT_W'(MAX_WINDOW));
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite
                      && (paddr[wmss_pkg::ADDR_W-1 -: wmss_pkg::REG_IDX_W]
                          == wmss_pkg::REG_RESULT_MODE);
    assign prdata   = (paddr[wmss_pkg::ADDR_W-1 -: wmss_pkg::REG_IDX_W]
                       == wmss_pkg::REG_RESULT_MODE)
                      ? wmss_pkg::APB_DATA_W'(r_mode) : '0;

    // magnitudes of the current sample channel and of its running sum
    assign w_smag = r_smp[r_ch][SMP_W-1] ? (~$unsigned(r_smp[r_ch]) + SMP_W'(1))
                                         : $unsigned(r_smp[r_ch]);
    assign w_mag  = r_sum[r_ch][SUM_W-1] ? (~$unsigned(r_sum[r_ch]) + SUM_W'(1))
                                         : $unsigned(r_sum[r_ch]);

    // shared multiplier
    always_comb begin
        case (r_state)
            S_SQ: begin
                w_mul_a = MA_W'(w_smag);
                w_mul_b = MB_W'(w_smag);
            end
            S_M1: begin
                w_mul_a = MA_W'(w_mag);
                w_mul_b = w_mag;
            end
            S_M2: begin
                w_mul_a = r_sq[r_ch];
                w_mul_b = MB_W'(r_cnt);
            end
            S_NN: begin
                w_mul_a = MA_W'(r_cnt);
                w_mul_b = MB_W'(r_cnt);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_mul = P_W'(w_mul_a) * P_W'(w_mul_b);

    // D = N*S2 - S1^2, floored at zero
    assign w_dpos = (r_prod[D_W-1:0] >= r_a);
    assign w_d    = w_dpos ? (r_prod[D_W-1:0] - r_a) : '0;

    // shared subtract/compare step: bit pair of the root or one quotient bit
    always_comb begin
        if (r_state == S_RT) begin
            w_cand  = {r_rem[R_W-3:0], r_x[X_W-1 -: 2]};
            w_trial = R_W'({r_root, 2'b01});
        end else begin
            w_cand  = {r_rem[R_W-2:0], r_x[X_W-1]};
            w_trial = R_W'(r_dvs);
        end
        w_ge   = (w_cand >= w_trial);
        w_diff = w_cand - w_trial;
        n_rem  = w_ge ? w_diff : w_cand;
        n_root = {r_root[RT_W-2:0], w_ge};
        n_quo  = {r_x[X_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_smp[0] <= i_accel_x;
                    r_smp[1] <= i_accel_y;
                    r_smp[2] <= i_accel_z;
                    r_smp[3] <= i_gyro_x;
                    r_smp[4] <= i_gyro_y;
                    r_smp[5] <= i_gyro_z;
                    r_end    <= i_window_end;
                    r_ch     <= '0;
                    if (!w_full) begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= S_SQ;
                    end else begin
                        r_ovf_seen <= 1'b1;
                        if (i_window_end) begin
                            r_state <= S_M1;
                        end
                    end
                end
            end
            S_SQ: begin
                r_prod       <= w_mul;
                r_sum[r_ch]  <= r_sum[r_ch] + {{(SUM_W-SMP_W){r_smp[r_ch][SMP_W-1]}},
                                               r_smp[r_ch]};
                r_state      <= S_SA;
            end
            S_SA: begin
                r_sq[r_ch] <= r_sq[r_ch] + r_prod[SQ_W-1:0];
                if (r_ch == wmss_pkg::LAST_CH) begin
                    r_ch    <= '0;
                    r_state <= r_end ? S_M1 : S_IDLE;
                end else begin
                    r_ch    <= r_ch + CH_W'(1);
                    r_state <= S_SQ;
                end
            end
            S_M1: begin
                r_prod  <= w_mul;
                r_state <= S_M2;
            end
            S_M2: begin
                r_a     <= r_prod[D_W-1:0];
                r_prod  <= w_mul;
                r_state <= S_D;
            end
            S_D: begin
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
                if (r_mode == wmss_pkg::MODE_VARIANCE) begin
                    r_x     <= X_W'(w_d);
                    r_state <= S_NN;
                end else begin
                    r_x     <= X_W'({w_d, {SCL_W{1'b0}}});
                    r_state <= S_RT;
                end
            end
            S_NN: begin
                r_dvs   <= w_mul[DVS_W-1:0];
                r_state <= S_DV;
            end
            S_RT: begin
                r_x    <= {r_x[X_W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(RT_W - 1)) begin
                    // root done: divide it by N
                    r_x     <= X_W'(n_root);
                    r_dvs   <= DVS_W'(r_cnt);
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DV;
                end
            end
            S_DV: begin
                r_x    <= n_quo;
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(X_W - 1)) begin
                    r_spread[r_ch] <= n_quo[SPR_W-1:0];
                    if (r_ch == wmss_pkg::LAST_CH) begin
                        r_done     <= 1'b1;
                        r_used     <= w_cnt_ext[USED_W-1:0];
                        r_ovf_out  <= r_ovf_seen;
                        r_cnt      <= '0;
                        r_ovf_seen <= 1'b0;
                        for (int c = 0; c < CHN; c++) begin
                            r_sum[c] <= '0;
                            r_sq[c]  <= '0;
                        end
                        r_state    <= S_IDLE;
                    end else begin
                        r_ch    <= r_ch + CH_W'(1);
                        r_state <= S_M1;
                    end
                end
            end
            default: begin
                r_state <= S_IDLE;
            end
        endcase

        if (w_cfg_wr) begin
            r_mode <= pwdata[0];
        end

        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ch       <= '0;
            r_step     <= '0;
            r_cnt      <= '0;
            r_ovf_seen <= 1'b0;
            r_mode     <= wmss_pkg::MODE_STDDEV;
            r_done     <= 1'b0;
            for (int c = 0; c < CHN; c++) begin
                r_sum[c] <= '0;
                r_sq[c]  <= '0;
            end
        end
    end

    assign w_cnt_ext = (CNT_W + USED_W)'(r_cnt);

    assign o_valid           = r_done;
    assign o_accel_x_spread  = r_spread[0];
    assign o_accel_y_spread  = r_spread[1];
    assign o_accel_z_spread  = r_spread[2];
    assign o_gyro_x_spread   = r_spread[3];
    assign o_gyro_y_spread   = r_spread[4];
    assign o_gyro_z_spread   = r_spread[5];
    assign o_samples_used    = r_used;
    assign o_window_overflow = r_ovf_out;

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && r_cnt == '0 && !r_ovf_seen))
        else $error("window not cleared with its result");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_WINDOW))
        else $error("sample count beyond window capacity");

    a_full_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full) |=> (r_ovf_seen && r_cnt == $past(r_cnt)))
        else $error("sample taken into a full window");

endmodule

/* tb/tb.sv */
module tb;
    import wmss_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    // longest window end (standard deviation) plus one sample, with margin
    localparam int SETTLE_CYCLES = 700;
    localparam int FULL_WINDOW   = DEF_MAX_WINDOW;

    localparam logic [ADDR_W-1:0] ADDR_MODE  = {REG_RESULT_MODE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_MODE + 3'd4;

    localparam t_sample S_MAX = 16'sh7FFF;
    localparam t_sample S_MIN = 16'sh8000;

    typedef enum logic [1:0] {ACT_SAMPLE, ACT_WRITE, ACT_READ, ACT_SETTLE} act_e;

    typedef enum logic [2:0] {
        DRV_FETCH, DRV_SAMPLE, DRV_GAP, DRV_SETUP, DRV_ACCESS, DRV_SETTLE, DRV_HOLD, DRV_DONE
    } drv_state_e;

    typedef struct packed {
        act_e                              act;
        logic [CHANNELS-1:0][SMP_W-1:0]    smp;
        logic                              ends_window;
        int                                gap;
        logic [ADDR_W-1:0]                 addr;
        logic [APB_DATA_W-1:0]             data;
    } step_t;

    typedef struct packed {
        logic [CHANNELS-1:0][SPREAD_W-1:0] spread;
        logic [USED_W-1:0]                 used;
        logic                              overflow;
    } window_result_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [APB_DATA_W-1:0]      pwdata = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [SMP_W-1:0]    i_accel_x = '0;
    logic signed [SMP_W-1:0]    i_accel_y = '0;
    logic signed [SMP_W-1:0]    i_accel_z = '0;
    logic signed [SMP_W-1:0]    i_gyro_x = '0;
    logic signed [SMP_W-1:0]    i_gyro_y = '0;
    logic signed [SMP_W-1:0]    i_gyro_z = '0;
    logic                       i_window_end = 1'b0;
    logic                       o_valid;
    logic [SPREAD_W-1:0]        o_accel_x_spread;
    logic [SPREAD_W-1:0]        o_accel_y_spread;
    logic [SPREAD_W-1:0]        o_accel_z_spread;
    logic [SPREAD_W-1:0]        o_gyro_x_spread;
    logic [SPREAD_W-1:0]        o_gyro_y_spread;
    logic [SPREAD_W-1:0]        o_gyro_z_spread;
    logic [USED_W-1:0]          o_samples_used;
    logic                       o_window_overflow;

    window_mean_stddev_six_axis uut (.*);

    step_t           sample_plan [$];
    window_result_t  pending_spreads [$];
    step_t           cur;
    drv_state_e      drv_state = DRV_FETCH;
    int              wait_left = 0;
    int              n_errors = 0;
    int              cycle_count = 0;

    // predicted block state
    logic            cfg_mode = MODE_STDDEV;
    int              acc_count = 0;
    longint          acc_sum [CHANNELS];
    longint unsigned acc_sqsum [CHANNELS];
    logic            acc_overflow = 1'b0;

    string ch_label [CHANNELS] = '{"accel_x", "accel_y", "accel_z",
                                   "gyro_x", "gyro_y", "gyro_z"};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag(input string msg);
        $display("ERROR: %s", msg);
        n_errors++;
    endtask

    function automatic logic [SPREAD_W-1:0] channel_spread(input longint sum,
            input longint unsigned sqsum, input int count, input logic mode);
        longint unsigned nn, mag, prod, d, x, r, trial;
        if (count == 0)
            return '0;
        nn   = longint'(count);
        mag  = (sum < 0) ? longint'(-sum) : longint'(sum);
        prod = nn * sqsum;
        d    = (prod >= mag * mag) ? prod - mag * mag : 64'd0;
        if (mode == MODE_VARIANCE)
            return SPREAD_W'(d / (nn * nn));
        // floor(sqrt(d * 2^16)), built up one bit at a time from the top
        x = d << SCALE_W;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x)
                r = trial;
        end
        return SPREAD_W'(r / nn);
    endfunction

    task automatic fold_sample(input step_t s);
        window_result_t res;
        longint v;
        if (acc_count < FULL_WINDOW) begin
            for (int c = 0; c < CHANNELS; c++) begin
                v = longint'($signed(s.smp[c]));
                acc_sum[c]   += v;
                acc_sqsum[c] += longint'(v * v);
            end
            acc_count++;
        end else begin
            acc_overflow = 1'b1;
        end
        if (s.ends_window) begin
            for (int c = 0; c < CHANNELS; c++)
                res.spread[c] = channel_spread(acc_sum[c], acc_sqsum[c], acc_count, cfg_mode);
            res.used     = USED_W'(acc_count);
            res.overflow = acc_overflow;
            pending_spreads.push_back(res);
            acc_count    = 0;
            acc_overflow = 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                acc_sum[c]   = 0;
                acc_sqsum[c] = 0;
            end
        end
    endtask

    function automatic logic [CHANNELS-1:0][SMP_W-1:0] six(input t_sample ax, ay, az,
            gx, gy, gz);
        return {gz, gy, gx, az, ay, ax};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 15);
        return $urandom_range(20, 120);
    endfunction

    function automatic t_sample pick_sample(input int style, input int bias);
        case (style)
            0: return t_sample'($urandom_range(0, 65535));
            1: return t_sample'(bias + int'($urandom_range(0, 200)) - 100);
            default: begin
                case ($urandom_range(0, 4))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return t_sample'(0);
                    3: return t_sample'(-1);
                    default: return t_sample'($urandom_range(0, 65535));
                endcase
            end
        endcase
    endfunction

    task automatic plan_sample(input logic [CHANNELS-1:0][SMP_W-1:0] smp,
            input logic ends_window, input int gap);
        step_t s;
        s = '0;
        s.act         = ACT_SAMPLE;
        s.smp         = smp;
        s.ends_window = ends_window;
        s.gap         = gap;
        sample_plan.push_back(s);
    endtask

    task automatic plan_reg(input act_e act, input logic [ADDR_W-1:0] addr,
            input logic [APB_DATA_W-1:0] data);
        step_t s;
        s = '0;
        s.act  = act;
        s.addr = addr;
        s.data = data;
        sample_plan.push_back(s);
    endtask

    task automatic plan_settle();
        step_t s;
        s = '0;
        s.act = ACT_SETTLE;
        sample_plan.push_back(s);
    endtask

    task automatic plan_extremes();
        plan_sample(six(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX), 1'b1, 0);
        plan_sample(six(S_MIN, 0, S_MAX, -1, S_MIN, 12345), 1'b0, 2);
        plan_sample(six(S_MAX, -1, S_MIN, 1, S_MIN, -12345), 1'b1, 0);
        // full-swing square wave: largest spread the fields allow
        for (int i = 0; i < 4; i++)
            plan_sample((i % 2) ? six(S_MAX, S_MIN, S_MAX, S_MIN, 0, 1)
                                : six(S_MIN, S_MAX, S_MIN, S_MAX, 0, -1), i == 3, i);
    endtask

    task automatic plan_window(input int len, input logic calm);
        logic [CHANNELS-1:0][SMP_W-1:0] smp;
        int bias [CHANNELS];
        int style;
        style = $urandom_range(0, 9);
        style = (style < 4) ? 0 : (style < 8) ? 1 : 2;
        for (int c = 0; c < CHANNELS; c++)
            bias[c] = int'($urandom_range(0, 60000)) - 30000;
        for (int i = 0; i < len; i++) begin
            for (int c = 0; c < CHANNELS; c++)
                smp[c] = pick_sample(style, bias[c]);
            plan_sample(smp, i == len - 1, calm ? 0 : pick_gap());
        end
    endtask

    initial begin : fill_plan
        logic [APB_DATA_W-1:0] word;
        int budget;
        int len;
        plan_reg(ACT_READ, ADDR_MODE, '0);
        plan_extremes();
        plan_settle();
        plan_reg(ACT_WRITE, ADDR_MODE, {{(APB_DATA_W-1){1'b0}}, MODE_VARIANCE});
        plan_reg(ACT_READ, ADDR_MODE, '0);
        plan_extremes();
        // write to an unmapped address is dropped, then upper bits of the value are dropped
        plan_settle();
        plan_reg(ACT_WRITE, ADDR_SPARE, '0);
        plan_reg(ACT_READ, ADDR_MODE, '0);
        plan_reg(ACT_WRITE, ADDR_MODE, 32'hFFFF_FFFE);
        plan_reg(ACT_READ, ADDR_MODE, '0);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                plan_settle();
                word    = $urandom;
                word[0] = ph[0] ? MODE_VARIANCE : MODE_STDDEV;
                plan_reg(ACT_WRITE, ADDR_MODE, word);
                plan_reg(ACT_READ, ADDR_MODE, '0);
            end
            // window full: one ending on the first refused sample, one running past it
            if (ph == 1)
                plan_window(FULL_WINDOW + 1, 1'b0);
            if (ph == 4)
                plan_window(FULL_WINDOW + 5, 1'b0);
            budget = 20;
            while (budget > 0) begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
                plan_window(len, $urandom_range(0, 4) == 0);
                budget -= len;
            end
        end
    end

    always @(posedge i_clk) begin : feed
        step_t nxt;
        logic  fetch;
        if (!i_rst_n) begin
            drv_state <= DRV_FETCH;
            start     <= 1'b0;
            psel      <= 1'b0;
            penable   <= 1'b0;
            cfg_mode  <= MODE_STDDEV;
        end else begin
            fetch = 1'b0;
            case (drv_state)
                DRV_FETCH: fetch = 1'b1;
                DRV_SAMPLE: if (!busy) begin
                    fold_sample(cur);
                    if (cur.gap == 0) begin
                        fetch = 1'b1;
                    end else begin
                        start     <= 1'b0;
                        wait_left <= cur.gap;
                        drv_state <= DRV_GAP;
                    end
                end
                DRV_GAP: begin
                    if (wait_left <= 1)
                        fetch = 1'b1;
                    else
                        wait_left <= wait_left - 1;
                end
                DRV_SETUP: begin
                    penable   <= 1'b1;
                    drv_state <= DRV_ACCESS;
                end
                DRV_ACCESS: if (pready) begin
                    if (cur.act == ACT_WRITE) begin
                        if (paddr == ADDR_MODE)
                            cfg_mode <= pwdata[0];
                    end else if (prdata !== {{(APB_DATA_W-1){1'b0}}, cfg_mode}) begin
                        flag($sformatf("result_mode read: got %0h expected %0h",
                                       prdata, cfg_mode));
                    end
                    psel      <= 1'b0;
                    penable   <= 1'b0;
                    drv_state <= DRV_FETCH;
                end
                DRV_SETTLE: if (pending_spreads.size() == 0) begin
                    // a sample without window end may still be in flight
                    wait_left <= SETTLE_CYCLES;
                    drv_state <= DRV_HOLD;
                end
                DRV_HOLD: begin
                    if (wait_left <= 1)
                        fetch = 1'b1;
                    else
                        wait_left <= wait_left - 1;
                end
                default: ;
            endcase

            if (fetch) begin
                if (sample_plan.size() == 0) begin
                    start     <= 1'b0;
                    drv_state <= DRV_DONE;
                end else begin
                    nxt = sample_plan.pop_front();
                    cur <= nxt;
                    if (nxt.act == ACT_SAMPLE) begin
                        start        <= 1'b1;
                        i_accel_x    <= nxt.smp[0];
                        i_accel_y    <= nxt.smp[1];
                        i_accel_z    <= nxt.smp[2];
                        i_gyro_x     <= nxt.smp[3];
                        i_gyro_y     <= nxt.smp[4];
                        i_gyro_z     <= nxt.smp[5];
                        i_window_end <= nxt.ends_window;
                        drv_state    <= DRV_SAMPLE;
                    end else if (nxt.act == ACT_SETTLE) begin
                        start     <= 1'b0;
                        drv_state <= DRV_SETTLE;
                    end else begin
                        start     <= 1'b0;
                        psel      <= 1'b1;
                        penable   <= 1'b0;
                        pwrite    <= (nxt.act == ACT_WRITE);
                        paddr     <= nxt.addr;
                        pwdata    <= nxt.data;
                        drv_state <= DRV_SETUP;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        window_result_t want;
        window_result_t got;
        if (i_rst_n && o_valid) begin
            got.spread[0] = o_accel_x_spread;
            got.spread[1] = o_accel_y_spread;
            got.spread[2] = o_accel_z_spread;
            got.spread[3] = o_gyro_x_spread;
            got.spread[4] = o_gyro_y_spread;
            got.spread[5] = o_gyro_z_spread;
            got.used      = o_samples_used;
            got.overflow  = o_window_overflow;
            if (pending_spreads.size() == 0) begin
                flag($sformatf("result at cycle %0d with no window pending", cycle_count));
            end else begin
                want = pending_spreads.pop_front();
                for (int c = 0; c < CHANNELS; c++)
                    if (got.spread[c] !== want.spread[c])
                        flag($sformatf("%s spread: got %0d expected %0d (mode %0d)",
                                       ch_label[c], got.spread[c], want.spread[c], cfg_mode));
                if (got.used !== want.used)
                    flag($sformatf("samples_used: got %0d expected %0d", got.used, want.used));
                if (got.overflow !== want.overflow)
                    flag($sformatf("window_overflow: got %0d expected %0d",
                                   got.overflow, want.overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("window_mean_stddev_six_axis regression: fail");
            $finish;
        end
    end

    initial begin : run_control
        for (int c = 0; c < CHANNELS; c++) begin
            acc_sum[c]   = 0;
            acc_sqsum[c] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(drv_state == DRV_DONE && pending_spreads.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("window_mean_stddev_six_axis regression: pass");
        else
            $display("window_mean_stddev_six_axis regression: fail");
        $finish;
    end

endmodule
